// ===== rtl/rse_pkg.sv =====
// Shared types, constants and codes for the RPN stack evaluator.
package rse_pkg;

   localparam int SYM_W = 8;
   localparam int VALUE_W = 48;
   localparam int DEPTH_OUT_W = 5;
   localparam int ERR_W = 2;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [SYM_W-1:0] SYM_ADD = 8'd43;
   localparam logic [SYM_W-1:0] SYM_SUB = 8'd45;
   localparam logic [SYM_W-1:0] SYM_MUL = 8'd42;
   localparam logic [SYM_W-1:0] SYM_DIV = 8'd47;
   localparam logic [SYM_W-1:0] CODE_BIAS = 8'd48;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 2'd0,
      ERR_FULL     = 2'd1,
      ERR_DIV_ZERO = 2'd2,
      ERR_SAT      = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EXEC,
      ST_FINISH
   } ctl_state_type;

   typedef enum logic [2:0] {
      ALU_IDLE,
      ALU_MUL,
      ALU_DIV,
      ALU_SAT,
      ALU_DONE
   } alu_state_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_req_type;

   typedef struct packed {
      logic    done;
      err_type err;
   } alu_rsp_type;

endpackage

// ===== rtl/rse_stack_mem.sv =====
// Stack storage: one write port and one read port with registered read data.
module rse_stack_mem #(
   parameter int DEPTH = rse_pkg::STACK_DEPTH_DEF,
   parameter int WIDTH = rse_pkg::VALUE_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rse_alu.sv =====
// Multi-cycle fixed-point arithmetic unit: add, subtract, multiply and divide.
module rse_alu #(
   parameter int FRAC_BITS = rse_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rse_pkg::alu_req_type         alu_req,
   input  logic [rse_pkg::VALUE_W-1:0]  left_value,
   input  logic [rse_pkg::VALUE_W-1:0]  right_value,
   output rse_pkg::alu_rsp_type         alu_rsp,
   output logic [rse_pkg::VALUE_W-1:0]  result_value
);

   localparam int VW = rse_pkg::VALUE_W;
   localparam int HALF_W = VW / 2;
   localparam int PROD_W = 2 * VW;
   localparam int DIV_W = VW + FRAC_BITS;
   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam int MUL_STEPS = 4;

   rse_pkg::alu_state_type state_ff, state_in;
   rse_pkg::op_type        op_ff;
   rse_pkg::err_type       err_ff;
   logic                   neg_ff;
   logic [VW-1:0]          mag_a_ff;
   logic [VW-1:0]          mag_b_ff;
   logic [PROD_W-1:0]      acc_ff;
   logic [VW-1:0]          pp_ff;
   logic [1:0]             pp_shift_ff;
   logic [DIV_W-1:0]       quo_ff;
   logic [VW-1:0]          rem_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [VW-1:0]          result_ff;

   logic [VW-1:0]     mag_left;
   logic [VW-1:0]     mag_right;
   logic [VW:0]       sum_ext;
   logic              sum_over;
   logic [VW-1:0]     sum_sat;
   logic [HALF_W-1:0] a_sel;
   logic [HALF_W-1:0] b_sel;
   logic [VW-1:0]     pp_next;
   logic [PROD_W-1:0] pp_term;
   logic [VW:0]       trial;
   logic              trial_ge;
   logic [PROD_W-1:0] mul_shift;
   logic [VW-1:0]     sel_mag;
   logic              sel_big;
   logic              sat_over;
   logic [VW-1:0]     sat_value;
   logic              right_zero;

   assign mag_left = left_value[VW-1] ? (~left_value + 1'b1) : left_value;
   assign mag_right = right_value[VW-1] ? (~right_value + 1'b1) : right_value;
   assign right_zero = (right_value == '0);

   always_comb begin
      if (alu_req.op == rse_pkg::OP_SUB) begin
         sum_ext = {left_value[VW-1], left_value} - {right_value[VW-1], right_value};
      end else begin
         sum_ext = {left_value[VW-1], left_value} + {right_value[VW-1], right_value};
      end
      sum_over = (sum_ext[VW] != sum_ext[VW-1]);
      if (sum_over) begin
         sum_sat = sum_ext[VW] ? rse_pkg::VALUE_MIN : rse_pkg::VALUE_MAX;
      end else begin
         sum_sat = sum_ext[VW-1:0];
      end
   end

   assign a_sel = cnt_ff[1] ? mag_a_ff[VW-1:HALF_W] : mag_a_ff[HALF_W-1:0];
   assign b_sel = cnt_ff[0] ? mag_b_ff[VW-1:HALF_W] : mag_b_ff[HALF_W-1:0];
   assign pp_next = VW'(a_sel) * VW'(b_sel);

   always_comb begin
      case (pp_shift_ff)
         2'd1:    pp_term = PROD_W'(pp_ff) << HALF_W;
         2'd2:    pp_term = PROD_W'(pp_ff) << VW;
         default: pp_term = PROD_W'(pp_ff);
      endcase
   end

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign trial_ge = (trial >= {1'b0, mag_b_ff});

   always_comb begin
      mul_shift = acc_ff >> FRAC_BITS;
      if (op_ff == rse_pkg::OP_MUL) begin
         sel_mag = mul_shift[VW-1:0];
         sel_big = ((mul_shift >> VW) != '0);
      end else begin
         sel_mag = quo_ff[VW-1:0];
         sel_big = ((quo_ff >> VW) != '0);
      end
      if (neg_ff) begin
         sat_over = sel_big || (sel_mag > rse_pkg::VALUE_MIN);
         sat_value = sat_over ? rse_pkg::VALUE_MIN : (~sel_mag + 1'b1);
      end else begin
         sat_over = sel_big || sel_mag[VW-1];
         sat_value = sat_over ? rse_pkg::VALUE_MAX : sel_mag;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rse_pkg::ALU_IDLE: begin
            if (alu_req.start) begin
               case (alu_req.op)
                  rse_pkg::OP_MUL: state_in = rse_pkg::ALU_MUL;
                  rse_pkg::OP_DIV: state_in = right_zero ? rse_pkg::ALU_DONE : rse_pkg::ALU_DIV;
                  default:         state_in = rse_pkg::ALU_DONE;
               endcase
            end
         end
         rse_pkg::ALU_MUL: begin
            if (cnt_ff == CNT_W'(MUL_STEPS)) begin
               state_in = rse_pkg::ALU_SAT;
            end
         end
         rse_pkg::ALU_DIV: begin
            if (cnt_ff == '0) begin
               state_in = rse_pkg::ALU_SAT;
            end
         end
         rse_pkg::ALU_SAT:  state_in = rse_pkg::ALU_DONE;
         rse_pkg::ALU_DONE: state_in = rse_pkg::ALU_IDLE;
         default:           state_in = rse_pkg::ALU_IDLE;
      endcase
   end

   always_comb begin
      alu_rsp.done = (state_ff == rse_pkg::ALU_DONE);
      alu_rsp.err = err_ff;
      result_value = result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rse_pkg::ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rse_pkg::ALU_IDLE: begin
            if (alu_req.start) begin
               op_ff <= alu_req.op;
               neg_ff <= left_value[VW-1] ^ right_value[VW-1];
               mag_a_ff <= mag_left;
               mag_b_ff <= mag_right;
               acc_ff <= '0;
               rem_ff <= '0;
               quo_ff <= DIV_W'(mag_left) << FRAC_BITS;
               case (alu_req.op)
                  rse_pkg::OP_MUL: begin
                     cnt_ff <= '0;
                  end
                  rse_pkg::OP_DIV: begin
                     cnt_ff <= CNT_W'(DIV_W - 1);
                     result_ff <= left_value[VW-1] ? rse_pkg::VALUE_MIN : rse_pkg::VALUE_MAX;
                     err_ff <= rse_pkg::ERR_DIV_ZERO;
                  end
                  default: begin
                     result_ff <= sum_sat;
                     err_ff <= sum_over ? rse_pkg::ERR_SAT : rse_pkg::ERR_NONE;
                  end
               endcase
            end
         end
         rse_pkg::ALU_MUL: begin
            if (cnt_ff < CNT_W'(MUL_STEPS)) begin
               pp_ff <= pp_next;
               pp_shift_ff <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            end
            if (cnt_ff != '0) begin
               acc_ff <= acc_ff + pp_term;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         rse_pkg::ALU_DIV: begin
            if (trial_ge) begin
               rem_ff <= VW'(trial - {1'b0, mag_b_ff});
            end else begin
               rem_ff <= trial[VW-1:0];
            end
            quo_ff <= {quo_ff[DIV_W-2:0], trial_ge};
            cnt_ff <= cnt_ff - 1'b1;
         end
         rse_pkg::ALU_SAT: begin
            result_ff <= sat_value;
            err_ff <= sat_over ? rse_pkg::ERR_SAT : rse_pkg::ERR_NONE;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/rpn_stack_evaluator_core.sv =====
// Top level of the RPN stack evaluator: request control, stack memory and arithmetic unit.
//
//   Channel  Ports                                          Direction  Handshake
//   request  req_symbol, req_end_of_expression              in         req_valid / req_ready
//   result   rsp_top_value, rsp_stack_depth,                out        rsp_valid / rsp_ready
//            rsp_error_code, rsp_final_res
//
// One request is in flight at a time. Divide uses a restoring divider that makes one quotient
// bit per cycle; a divide by zero skips it. Multiply runs as four 24 x 24 partial products
// through one multiplier. The left operand of an operator is read from the stack memory; the
// top entry is held in a register. Reset is synchronous and empties the stack; memory contents
// are not cleared. The next request is taken while a finished result waits in the output register.
module rpn_stack_evaluator_core #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS = rse_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rse_pkg::SYM_W-1:0]           req_symbol,
   input  logic                                req_end_of_expression,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rse_pkg::VALUE_W-1:0]  rsp_top_value,
   output logic [rse_pkg::DEPTH_OUT_W-1:0]     rsp_stack_depth,
   output logic [rse_pkg::ERR_W-1:0]           rsp_error_code,
   output logic                                rsp_final_res
);

   localparam int VW = rse_pkg::VALUE_W;
   localparam int SW = rse_pkg::SYM_W;
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   rse_pkg::ctl_state_type state_ff, state_in;
   rse_pkg::op_type        op_ff, op_in;
   logic                   is_op_ff, is_op_in;
   logic                   eoe_ff, eoe_in;
   logic [VW-1:0]          operand_ff, operand_in;
   logic [CNT_W-1:0]       depth_ff, depth_in;
   logic [VW-1:0]          top_ff, top_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]          rsp_top_ff, rsp_top_in;
   logic [rse_pkg::DEPTH_OUT_W-1:0] rsp_depth_ff, rsp_depth_in;
   rse_pkg::err_type       rsp_err_ff, rsp_err_in;
   logic                   rsp_final_ff, rsp_final_in;

   rse_pkg::op_type      op_dec;
   logic                 is_op_dec;
   logic [SW:0]          digit_diff;
   logic [VW-1:0]        digit_value;
   logic                 depth_ge2;
   logic [CNT_W-1:0]     depth_m2;
   logic [CNT_W-1:0]     pop_depth;
   logic                 accept;
   logic                 slot_free;
   logic                 finish_go;
   logic                 stack_full;
   logic                 push_en;
   logic [VW-1:0]        push_value;
   logic [ADDR_W-1:0]    push_addr;
   logic [CNT_W-1:0]     depth_after;
   logic [31:0]          depth_wide;
   rse_pkg::err_type     step_err;
   logic                 mem_rd_en;
   logic [VW-1:0]        mem_rd_data;
   logic [VW-1:0]        left_value;
   rse_pkg::alu_req_type alu_req;
   rse_pkg::alu_rsp_type alu_rsp;
   logic [VW-1:0]        alu_result;

   rse_stack_mem #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (VW)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (finish_go & push_en),
      .wr_addr (push_addr),
      .wr_data (push_value),
      .rd_en   (mem_rd_en),
      .rd_addr (depth_m2[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   rse_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock        (clock),
      .reset        (reset),
      .alu_req      (alu_req),
      .left_value   (left_value),
      .right_value  (operand_ff),
      .alu_rsp      (alu_rsp),
      .result_value (alu_result)
   );

   always_comb begin
      is_op_dec = 1'b1;
      op_dec = rse_pkg::OP_ADD;
      case (req_symbol)
         rse_pkg::SYM_ADD: op_dec = rse_pkg::OP_ADD;
         rse_pkg::SYM_SUB: op_dec = rse_pkg::OP_SUB;
         rse_pkg::SYM_MUL: op_dec = rse_pkg::OP_MUL;
         rse_pkg::SYM_DIV: op_dec = rse_pkg::OP_DIV;
         default:          is_op_dec = 1'b0;
      endcase
   end

   assign digit_diff = {1'b0, req_symbol} - {1'b0, rse_pkg::CODE_BIAS};
   assign digit_value = {{(VW-SW-1){digit_diff[SW]}}, digit_diff} << FRAC_BITS;

   assign depth_ge2 = (depth_ff >= CNT_W'(2));
   assign depth_m2 = depth_ff - CNT_W'(2);
   assign pop_depth = depth_ge2 ? depth_m2 : '0;
   assign left_value = depth_ge2 ? mem_rd_data : '0;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rse_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = is_op_dec ? rse_pkg::ST_LOAD : rse_pkg::ST_FINISH;
            end
         end
         rse_pkg::ST_LOAD: state_in = rse_pkg::ST_EXEC;
         rse_pkg::ST_EXEC: begin
            if (alu_rsp.done) begin
               state_in = rse_pkg::ST_FINISH;
            end
         end
         rse_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = rse_pkg::ST_IDLE;
            end
         end
         default: state_in = rse_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == rse_pkg::ST_IDLE);
      accept = req_ready && req_valid;
      mem_rd_en = accept && is_op_dec && depth_ge2;
      alu_req.start = (state_ff == rse_pkg::ST_LOAD);
      alu_req.op = op_ff;
      finish_go = (state_ff == rse_pkg::ST_FINISH) && slot_free;
   end

   always_comb begin
      stack_full = (depth_ff == CNT_W'(STACK_DEPTH));
      if (is_op_ff) begin
         push_en = 1'b1;
         push_value = alu_result;
         push_addr = pop_depth[ADDR_W-1:0];
         depth_after = pop_depth + 1'b1;
         step_err = alu_rsp.err;
      end else begin
         push_en = !stack_full;
         push_value = operand_ff;
         push_addr = depth_ff[ADDR_W-1:0];
         depth_after = stack_full ? depth_ff : depth_ff + 1'b1;
         step_err = stack_full ? rse_pkg::ERR_FULL : rse_pkg::ERR_NONE;
      end
      depth_wide = 32'(depth_after);
   end

   always_comb begin
      op_in = op_ff;
      is_op_in = is_op_ff;
      eoe_in = eoe_ff;
      operand_in = operand_ff;
      depth_in = depth_ff;
      top_in = top_ff;
      rsp_top_in = rsp_top_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_err_in = rsp_err_ff;
      rsp_final_in = rsp_final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         op_in = op_dec;
         is_op_in = is_op_dec;
         eoe_in = req_end_of_expression;
         if (is_op_dec) begin
            operand_in = (depth_ff != '0) ? top_ff : '0;
         end else begin
            operand_in = digit_value;
         end
      end
      if (finish_go) begin
         top_in = push_en ? push_value : top_ff;
         depth_in = eoe_ff ? '0 : depth_after;
         rsp_valid_in = 1'b1;
         rsp_top_in = push_en ? push_value : top_ff;
         rsp_depth_in = depth_wide[rse_pkg::DEPTH_OUT_W-1:0];
         rsp_err_in = step_err;
         rsp_final_in = eoe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rse_pkg::ST_IDLE;
         depth_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      is_op_ff <= is_op_in;
      eoe_ff <= eoe_in;
      operand_ff <= operand_in;
      top_ff <= top_in;
      rsp_top_ff <= rsp_top_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_err_ff <= rsp_err_in;
      rsp_final_ff <= rsp_final_in;
   end

   always_comb begin
      rsp_valid = rsp_valid_ff;
      rsp_top_value = rsp_top_ff;
      rsp_stack_depth = rsp_depth_ff;
      rsp_error_code = rsp_err_ff;
      rsp_final_res = rsp_final_ff;
   end

endmodule

// ===== rtl/rse_checker.sv =====
// Port-level checks for the RPN stack evaluator, bound to the top level.
module rse_checker #(
   parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rse_pkg::VALUE_W-1:0]        rsp_top_value,
   input logic [rse_pkg::DEPTH_OUT_W-1:0]    rsp_stack_depth,
   input logic [rse_pkg::ERR_W-1:0]          rsp_error_code
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_stack_depth) && $stable(rsp_error_code))
      else $error("A stalled result changed before it was taken.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A second request was taken while one was in progress.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == rse_pkg::ERR_DIV_ZERO) |->
         (rsp_top_value == rse_pkg::VALUE_MAX) || (rsp_top_value == rse_pkg::VALUE_MIN))
      else $error("A divide by zero did not give a saturated value.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == rse_pkg::ERR_FULL) |->
         rsp_stack_depth == rse_pkg::DEPTH_OUT_W'(STACK_DEPTH))
      else $error("A dropped push was reported with a stack that was not full.");

endmodule

bind rpn_stack_evaluator_core rse_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_rse_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_top_value   (rsp_top_value),
   .rsp_stack_depth (rsp_stack_depth),
   .rsp_error_code  (rsp_error_code)
);
